>>> rtl/pidfd_pkg.sv
// ----------------------------------------------------------------------------
// pidfd_pkg
// Shared types and constants of the filtered-derivative PID controller:
// field widths, register indexes, sequencer states and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package pidfd_pkg;

	localparam int unsigned DATA_W  = 16;
	localparam int unsigned GAIN_W  = 32;
	localparam int unsigned ERR_W   = 17;
	localparam int unsigned MUL_A_W = 33;
	localparam int unsigned MUL_B_W = 17;
	localparam int unsigned PROD_W  = 50;
	localparam int unsigned ACC_W   = 32;
	localparam int unsigned PTERM_W = 49;
	localparam int unsigned LAG_W   = 48;
	localparam int unsigned SUM_W   = 51;
	localparam int unsigned IDX_W   = 3;

	// Lag coefficients, k/65536, as positive signed multiplier operands.
	localparam logic signed [MUL_B_W-1:0] LAG1_GAIN = 17'sd25297;
	localparam logic signed [MUL_B_W-1:0] LAG2_GAIN = 17'sd28720;

	// Saturation bounds of the raw derivative, Q34.16.
	localparam logic signed [PROD_W-1:0] DSAT_HI = {4'b0000, {46{1'b1}}};
	localparam logic signed [PROD_W-1:0] DSAT_LO = {4'b1111, {46{1'b0}}};

	typedef enum logic [IDX_W-1:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_OUT_MIN,
		REG_OUT_MAX,
		REG_INTEG_MIN,
		REG_INTEG_MAX,
		REG_ENABLED
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_P,
		ST_I,
		ST_D,
		ST_DSAT,
		ST_DIFF,
		ST_MH,
		ST_ML,
		ST_UPD,
		ST_FIN,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		MUL_P,
		MUL_I,
		MUL_D,
		MUL_LH,
		MUL_LL
	} mul_sel_t;

	typedef enum logic [1:0] {
		LAG_2A,
		LAG_2B,
		LAG_1
	} lag_t;

	typedef struct packed {
		logic     in_ready;
		logic     start;
		mul_sel_t mul_sel;
		logic     ld_pterm;
		logic     ld_integ;
		logic     ld_draw;
		logic     ld_diff;
		logic     ld_hi;
		logic     ld_lag;
		logic     finish;
		logic     deliver;
		lag_t     stage;
	} ctl_t;

	typedef struct packed {
		logic fire;
		logic run;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/pid_filtered_derivative.sv
// ----------------------------------------------------------------------------
// pid_filtered_derivative
// PID controller with derivative on measurement, integrator anti-windup
// and a derivative smoothed by a second-order and a first-order lag.
// ----------------------------------------------------------------------------
// A running sample passes through the single 33x17 multiplier, used nine
// times, and through the three lag stages, which are updated one after the
// other. Disabled and priming samples skip both.
// A new sample is taken only after the result of the last one has gone
// into the output register.
// Reset (arst_n low) clears all controller state and configuration; the
// loop comes up enabled with zero gains and zero limits.
`default_nettype none

module pid_filtered_derivative
	import pidfd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// Configuration write port.
	input  wire logic              wr_en,
	input  wire logic [IDX_W-1:0]  wr_index,
	input  wire logic [GAIN_W-1:0] wr_data,
	// Input stream.
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [31:0]       s_tdata,   // [15:0] measurement, [31:16] setpoint
	// Output stream.
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [15:0]            m_tdata,   // [15:0] drive
	output logic [0:0]             m_tuser    // [0] initializing
);

	ctl_t ctl;
	sts_t sts;

	// Configuration registers.
	logic signed [GAIN_W-1:0] gain_p_q, gain_i_q, gain_d_q;
	logic signed [DATA_W-1:0] out_min_q, out_max_q, integ_min_q, integ_max_q;
	logic                     enabled_q;
	logic                     lc_q;

	// Controller state.
	logic signed [ACC_W-1:0]  integ_q;
	logic signed [DATA_W-1:0] prev_meas_q;
	logic signed [DATA_W-1:0] prev_drive_q;
	logic signed [LAG_W-1:0]  lag2a_q, lag2b_q, lag1_q;
	logic                     primed_q;

	// Per-sample working registers.
	logic signed [DATA_W-1:0]  meas_q;
	logic signed [ERR_W-1:0]   err_q, dmeas_q;
	logic signed [PTERM_W-1:0] pterm_q;
	logic signed [LAG_W-1:0]   draw_q, diff_q;
	logic signed [PROD_W-1:0]  hi_q;
	logic signed [DATA_W-1:0]  res_drive_q;
	logic                      res_init_q;

	// Output register.
	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;
	logic              m_tuser_q;

	logic                      s_fire;
	logic signed [DATA_W-1:0]  in_meas, in_sp;
	logic signed [DATA_W-1:0]  omin, omax, imin, imax;
	logic signed [ACC_W-1:0]   ilo32, ihi32, integ_lc;
	logic signed [DATA_W-1:0]  pd_clamp;
	logic signed [PROD_W-1:0]  ilo50, ihi50, integ_sum, integ_new;
	logic signed [PROD_W-1:0]  draw_sat;
	logic signed [LAG_W-1:0]   lag_x, lag_y;
	logic signed [MUL_B_W-1:0] lag_k;
	logic signed [PROD_W-1:0]  lag_new;
	logic signed [SUM_W-1:0]   olo51, ohi51, out_sum, out_clamped;
	logic signed [DATA_W-1:0]  drive_new;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  prod;

	assign s_fire       = s_tvalid && ctl.in_ready;
	assign s_tready     = ctl.in_ready;
	assign sts.fire     = s_fire;
	assign sts.run      = enabled_q && primed_q;
	assign sts.out_free = !m_tvalid_q || m_tready;

	assign in_meas = s_tdata[15:0];
	assign in_sp   = s_tdata[31:16];

	// Effective limits: an inverted pair counts as zero, and the integral
	// limits are narrowed into the output limits.
	always_comb begin
		omin = out_min_q;
		omax = out_max_q;
		imin = integ_min_q;
		imax = integ_max_q;
		if (out_min_q > out_max_q) begin
			omin = '0;
			omax = '0;
		end
		if (integ_min_q > integ_max_q) begin
			imin = '0;
			imax = '0;
		end
		if (imin < omin) imin = omin;
		if (imax > omax) imax = omax;
	end

	assign ilo32 = {imin, 16'h0000};
	assign ihi32 = {imax, 16'h0000};
	assign ilo50 = {{(PROD_W-ACC_W){imin[DATA_W-1]}}, imin, 16'h0000};
	assign ihi50 = {{(PROD_W-ACC_W){imax[DATA_W-1]}}, imax, 16'h0000};

	// Re-clamp after a limit change; the upper bound is tested first.
	always_comb begin
		if (prev_drive_q > omax)      pd_clamp = omax;
		else if (prev_drive_q < omin) pd_clamp = omin;
		else                          pd_clamp = prev_drive_q;
		if (integ_q > ihi32)          integ_lc = ihi32;
		else if (integ_q < ilo32)     integ_lc = ilo32;
		else                          integ_lc = integ_q;
	end

	// Integrator update with the ki*err product.
	assign integ_sum = {{(PROD_W-ACC_W){integ_q[ACC_W-1]}}, integ_q} + prod;
	always_comb begin
		if (integ_sum > ihi50)      integ_new = ihi50;
		else if (integ_sum < ilo50) integ_new = ilo50;
		else                        integ_new = integ_sum;
	end

	always_comb begin
		if (prod > DSAT_HI)      draw_sat = DSAT_HI;
		else if (prod < DSAT_LO) draw_sat = DSAT_LO;
		else                     draw_sat = prod;
	end

	always_comb begin
		unique case (ctl.stage)
			LAG_2A: begin
				lag_x = draw_q;
				lag_y = lag2a_q;
				lag_k = LAG2_GAIN;
			end
			LAG_2B: begin
				lag_x = lag2a_q;
				lag_y = lag2b_q;
				lag_k = LAG2_GAIN;
			end
			LAG_1: begin
				lag_x = lag2b_q;
				lag_y = lag1_q;
				lag_k = LAG1_GAIN;
			end
			default: begin
				lag_x = draw_q;
				lag_y = lag2a_q;
				lag_k = LAG2_GAIN;
			end
		endcase
	end

	// The difference is multiplied in two halves; the low half is unsigned
	// and nonnegative, so floor((hi*2^24 + lo) / 2^16) = hi*2^8 + (lo >> 16).
	assign lag_new = {{(PROD_W-LAG_W){lag_y[LAG_W-1]}}, lag_y} + (hi_q <<< 8)
		+ {16'h0000, prod[PROD_W-1:16]};

	assign out_sum = {{(SUM_W-PTERM_W){pterm_q[PTERM_W-1]}}, pterm_q}
		+ {{(SUM_W-ACC_W){integ_q[ACC_W-1]}}, integ_q}
		+ {{(SUM_W-LAG_W){lag1_q[LAG_W-1]}}, lag1_q};
	assign olo51 = {{(SUM_W-ACC_W){omin[DATA_W-1]}}, omin, 16'h0000};
	assign ohi51 = {{(SUM_W-ACC_W){omax[DATA_W-1]}}, omax, 16'h0000};
	always_comb begin
		if (out_sum > ohi51)      out_clamped = ohi51;
		else if (out_sum < olo51) out_clamped = olo51;
		else                      out_clamped = out_sum;
	end
	assign drive_new = out_clamped[31:16];

	always_comb begin
		unique case (ctl.mul_sel)
			MUL_P: begin
				mul_a = {gain_p_q[GAIN_W-1], gain_p_q};
				mul_b = err_q;
			end
			MUL_I: begin
				mul_a = {gain_i_q[GAIN_W-1], gain_i_q};
				mul_b = err_q;
			end
			MUL_D: begin
				mul_a = {gain_d_q[GAIN_W-1], gain_d_q};
				mul_b = dmeas_q;
			end
			MUL_LH: begin
				mul_a = {{(MUL_A_W-24){diff_q[LAG_W-1]}}, diff_q[LAG_W-1:24]};
				mul_b = lag_k;
			end
			MUL_LL: begin
				mul_a = {{(MUL_A_W-24){1'b0}}, diff_q[23:0]};
				mul_b = lag_k;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	pidfd_mul u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (prod)
	);

	pidfd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.ctl    (ctl)
	);

	// Configuration and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q     <= '0;
			gain_i_q     <= '0;
			gain_d_q     <= '0;
			out_min_q    <= '0;
			out_max_q    <= '0;
			integ_min_q  <= '0;
			integ_max_q  <= '0;
			enabled_q    <= 1'b1;
			lc_q         <= 1'b0;
			integ_q      <= '0;
			prev_meas_q  <= '0;
			prev_drive_q <= '0;
			lag2a_q      <= '0;
			lag2b_q      <= '0;
			lag1_q       <= '0;
			primed_q     <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (reg_idx_t'(wr_index))
					REG_GAIN_P:    gain_p_q <= wr_data;
					REG_GAIN_I:    gain_i_q <= wr_data;
					REG_GAIN_D:    gain_d_q <= wr_data;
					REG_OUT_MIN: begin
						out_min_q <= wr_data[DATA_W-1:0];
						lc_q      <= 1'b1;
					end
					REG_OUT_MAX: begin
						out_max_q <= wr_data[DATA_W-1:0];
						lc_q      <= 1'b1;
					end
					REG_INTEG_MIN: begin
						integ_min_q <= wr_data[DATA_W-1:0];
						lc_q        <= 1'b1;
					end
					REG_INTEG_MAX: begin
						integ_max_q <= wr_data[DATA_W-1:0];
						lc_q        <= 1'b1;
					end
					REG_ENABLED: begin
						enabled_q <= wr_data[0];
						if (!wr_data[0]) primed_q <= 1'b0;
					end
					default: lc_q <= lc_q;
				endcase
			end

			if (ctl.start) begin
				if (lc_q) begin
					prev_drive_q <= pd_clamp;
					integ_q      <= integ_lc;
					lc_q         <= 1'b0;
				end
				if (!enabled_q) begin
					primed_q <= 1'b0;
				end else if (!primed_q) begin
					integ_q      <= '0;
					prev_drive_q <= '0;
					prev_meas_q  <= meas_q;
					primed_q     <= 1'b1;
				end
			end

			// Integrate only while the previous drive lay strictly inside.
			if (ctl.ld_integ && prev_drive_q > omin && prev_drive_q < omax) begin
				integ_q <= integ_new[ACC_W-1:0];
			end

			if (ctl.ld_lag) begin
				unique case (ctl.stage)
					LAG_2A:  lag2a_q <= lag_new[LAG_W-1:0];
					LAG_2B:  lag2b_q <= lag_new[LAG_W-1:0];
					LAG_1:   lag1_q  <= lag_new[LAG_W-1:0];
					default: lag1_q  <= lag1_q;
				endcase
			end

			if (ctl.finish) begin
				prev_drive_q <= drive_new;
				prev_meas_q  <= meas_q;
			end
		end
	end

	// Working registers of the sample in progress.
	always_ff @(posedge clk) begin
		if (s_fire) begin
			meas_q  <= in_meas;
			err_q   <= ERR_W'(in_sp) - ERR_W'(in_meas);
			dmeas_q <= ERR_W'(prev_meas_q) - ERR_W'(in_meas);
		end
		if (ctl.start) begin
			res_drive_q <= '0;
			res_init_q  <= enabled_q && !primed_q;
		end
		if (ctl.ld_pterm) pterm_q <= prod[PTERM_W-1:0];
		if (ctl.ld_draw)  draw_q  <= draw_sat[LAG_W-1:0];
		if (ctl.ld_diff)  diff_q  <= lag_x - lag_y;
		if (ctl.ld_hi)    hi_q    <= prod;
		if (ctl.finish) begin
			res_drive_q <= drive_new;
			res_init_q  <= 1'b0;
		end
		if (ctl.deliver) begin
			m_tdata_q <= res_drive_q;
			m_tuser_q <= res_init_q;
		end
	end

	// A finished result waits here until the output transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.deliver) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	a_init_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("priming result carries a nonzero drive");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a sample is in progress");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.deliver |-> !m_tvalid_q || m_tready)
		else $error("result loaded over one not yet transferred");

	a_prime_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(primed_q) |-> res_init_q)
		else $error("state primed without an initializing result");

endmodule

`default_nettype wire

>>> rtl/pidfd_mul.sv
// ----------------------------------------------------------------------------
// pidfd_mul
// Shared signed multiplier with a registered product. Every gain product
// and both halves of each lag product go through this one unit.
// ----------------------------------------------------------------------------
`default_nettype none

module pidfd_mul
	import pidfd_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic signed [MUL_A_W-1:0] op_a,
	input  wire logic signed [MUL_B_W-1:0] op_b,
	output logic signed [PROD_W-1:0]       prod
);

	always_ff @(posedge clk) begin
		prod <= op_a * op_b;
	end

endmodule

`default_nettype wire

>>> rtl/pidfd_ctrl.sv
// ----------------------------------------------------------------------------
// pidfd_ctrl
// Sequencer of the controller. It steps a running sample through the gain
// products, the integrator update and the three lag stages, and hands the
// datapath its operand selects and load strobes.
// ----------------------------------------------------------------------------
`default_nettype none

module pidfd_ctrl
	import pidfd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire sts_t sts,
	output ctl_t      ctl
);

	state_t state_q, state_d;
	lag_t   lag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lag_q   <= LAG_2A;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DSAT) begin
				lag_q <= LAG_2A;
			end else if (state_q == ST_UPD) begin
				unique case (lag_q)
					LAG_2A:  lag_q <= LAG_2B;
					LAG_2B:  lag_q <= LAG_1;
					default: lag_q <= LAG_2A;
				endcase
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (sts.fire) state_d = ST_START;
			ST_START: state_d = sts.run ? ST_P : ST_DONE;
			ST_P:     state_d = ST_I;
			ST_I:     state_d = ST_D;
			ST_D:     state_d = ST_DSAT;
			ST_DSAT:  state_d = ST_DIFF;
			ST_DIFF:  state_d = ST_MH;
			ST_MH:    state_d = ST_ML;
			ST_ML:    state_d = ST_UPD;
			ST_UPD:   state_d = (lag_q == LAG_1) ? ST_FIN : ST_DIFF;
			ST_FIN:   state_d = ST_DONE;
			ST_DONE:  if (sts.out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl          = '0;
		ctl.mul_sel  = MUL_P;
		ctl.stage    = lag_q;
		unique case (state_q)
			ST_IDLE:  ctl.in_ready = 1'b1;
			ST_START: ctl.start = 1'b1;
			ST_P:     ctl.mul_sel = MUL_P;
			ST_I: begin
				ctl.mul_sel  = MUL_I;
				ctl.ld_pterm = 1'b1;
			end
			ST_D: begin
				ctl.mul_sel  = MUL_D;
				ctl.ld_integ = 1'b1;
			end
			ST_DSAT:  ctl.ld_draw = 1'b1;
			ST_DIFF:  ctl.ld_diff = 1'b1;
			ST_MH:    ctl.mul_sel = MUL_LH;
			ST_ML: begin
				ctl.mul_sel = MUL_LL;
				ctl.ld_hi   = 1'b1;
			end
			ST_UPD:   ctl.ld_lag = 1'b1;
			ST_FIN:   ctl.finish = 1'b1;
			ST_DONE:  ctl.deliver = sts.out_free;
			default:  ctl.in_ready = 1'b0;
		endcase
	end

endmodule

`default_nettype wire
